### src/rma_pkg.sv
// ----------------------------------------------------------------------------
// rma_pkg: shared types and constants of the resource map allocator
// Status codes, write-data selects and the controller/datapath interface.
// ----------------------------------------------------------------------------
package rma_pkg;

  localparam int MAP_ENTRIES_DEF = 16;
  localparam int ADDR_BITS_DEF   = 16;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

  // Source of the data written into the extent memory
  typedef enum logic [2:0] {
    WD_SHRINK,      // current entry, base advanced and length reduced
    WD_COPY,        // entry read last cycle, for table shifts
    WD_ZERO,        // empty entry
    WD_PREV_LEN,    // previous entry grown by the freed length
    WD_PREV_BOTH,   // previous entry grown by freed and next extents
    WD_NEW,         // freed extent as is
    WD_NEXT_MERGE   // freed extent joined with the current entry
  } wdsel_t;

  typedef struct packed {
    logic    load_req;
    logic    rd_en;
    logic    wr_en;
    wdsel_t  wr_sel;
    logic    save_prev;
    logic    res_set;
    logic    res_take_base;
    status_t res_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic reject;
    logic rd_zero;
    logic fits;
    logic exact;
    logic stop;
    logic overlap;
    logic end_eq;
    logic prev_adj;
  } sts_t;

endpackage

### src/rma_datapath.sv
// ----------------------------------------------------------------------------
// rma_datapath: extent memory and arithmetic
// Holds the request, the extent table with per-entry valid bits, the
// previous-entry registers, the result and the output register.
// ----------------------------------------------------------------------------
module rma_datapath #(
  parameter int MAP_ENTRIES = rma_pkg::MAP_ENTRIES_DEF,
  parameter int ADDR_BITS   = rma_pkg::ADDR_BITS_DEF,
  localparam int IW = $clog2(MAP_ENTRIES)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rma_pkg::cmd_t  cmd,
  input  logic [IW-1:0]  rd_addr,
  input  logic [IW-1:0]  wr_addr,
  input  logic [31:0]    in_tdata,   // [15:0] base_in, [31:16] length_in
  input  logic           in_tuser,   // [0] cmd
  output logic [15:0]    out_tdata,  // [15:0] base_out
  output logic [1:0]     out_tuser,  // [1:0] status
  output rma_pkg::sts_t  sts
);

  localparam int AW = ADDR_BITS;
  localparam int XW = ((AW > 16) ? AW : 16) + 2;
  localparam logic [XW-1:0] MASK_X = {{(XW-AW){1'b0}}, {AW{1'b1}}};

  logic [2*AW-1:0]     mem [MAP_ENTRIES];
  logic [MAP_ENTRIES-1:0] valid_r;
  logic [2*AW-1:0]     rd_data_r;

  logic                req_free_r;
  logic [15:0]         req_base_r;
  logic [15:0]         req_len_r;
  logic [AW-1:0]       pbase_r;
  logic [AW-1:0]       plen_r;
  logic [15:0]         res_base_r;
  rma_pkg::status_t    res_code_r;
  logic [15:0]         out_base_r;
  rma_pkg::status_t    out_code_r;

  logic [AW-1:0]       rbase;
  logic [AW-1:0]       rlen;
  logic [XW-1:0]       base_x, len_x, end_x, rbase_x, rlen_x, prev_end_x;
  logic [XW-1:0]       shrink_base_x, shrink_len_x, prev_len_x, both_len_x, next_len_x;
  logic [2*AW-1:0]     wr_data;

  assign rbase = rd_data_r[2*AW-1:AW];
  assign rlen  = rd_data_r[AW-1:0];

  assign base_x        = XW'(req_base_r);
  assign len_x         = XW'(req_len_r);
  assign end_x         = base_x + len_x;
  assign rbase_x       = XW'(rbase);
  assign rlen_x        = XW'(rlen);
  assign prev_end_x    = XW'(pbase_r) + XW'(plen_r);
  assign shrink_base_x = rbase_x + len_x;
  assign shrink_len_x  = rlen_x - len_x;
  assign prev_len_x    = XW'(plen_r) + len_x;
  assign both_len_x    = prev_len_x + rlen_x;
  assign next_len_x    = rlen_x + len_x;

  always_comb begin
    sts.is_free  = req_free_r;
    sts.reject   = (req_len_r == 16'd0) || (end_x > MASK_X);
    sts.rd_zero  = (rlen == '0);
    sts.fits     = (rlen_x >= len_x);
    sts.exact    = (rlen_x == len_x);
    sts.stop     = (base_x < rbase_x) || (rlen == '0);
    sts.overlap  = (rlen != '0) && (end_x > rbase_x);
    sts.end_eq   = (end_x == rbase_x);
    sts.prev_adj = (prev_end_x == base_x);
  end

  always_comb begin
    case (cmd.wr_sel)
      rma_pkg::WD_SHRINK:     wr_data = {shrink_base_x[AW-1:0], shrink_len_x[AW-1:0]};
      rma_pkg::WD_COPY:       wr_data = rd_data_r;
      rma_pkg::WD_ZERO:       wr_data = '0;
      rma_pkg::WD_PREV_LEN:   wr_data = {pbase_r, prev_len_x[AW-1:0]};
      rma_pkg::WD_PREV_BOTH:  wr_data = {pbase_r, both_len_x[AW-1:0]};
      rma_pkg::WD_NEW:        wr_data = {base_x[AW-1:0], len_x[AW-1:0]};
      rma_pkg::WD_NEXT_MERGE: wr_data = {base_x[AW-1:0], next_len_x[AW-1:0]};
      default:                wr_data = '0;
    endcase
  end

  // Extent memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  // Valid bits: an entry never written reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_free_r <= in_tuser;
      req_base_r <= in_tdata[15:0];
      req_len_r  <= in_tdata[31:16];
    end
    if (cmd.save_prev) begin
      pbase_r <= rbase;
      plen_r  <= rlen;
    end
    if (cmd.res_set) begin
      res_code_r <= cmd.res_code;
      res_base_r <= cmd.res_take_base ? rbase_x[15:0] : 16'd0;
    end
    if (cmd.out_load) begin
      out_base_r <= res_base_r;
      out_code_r <= res_code_r;
    end
  end

  assign out_tdata = out_base_r;
  assign out_tuser = out_code_r;

endmodule

### src/rma_ctrl.sv
// ----------------------------------------------------------------------------
// rma_ctrl: sequencer of the resource map allocator
// Scans the table one entry a cycle, then drives shrink, merge, insert and
// table shifts, and hands the result to the output register.
// ----------------------------------------------------------------------------
module rma_ctrl #(
  parameter int MAP_ENTRIES = rma_pkg::MAP_ENTRIES_DEF,
  localparam int IW = $clog2(MAP_ENTRIES)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rma_pkg::sts_t  sts,
  output rma_pkg::cmd_t  cmd,
  output logic [IW-1:0]  rd_addr,
  output logic [IW-1:0]  wr_addr,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready
);

  localparam logic [IW-1:0] LAST = IW'(MAP_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHDN,
    S_CLR,
    S_UPCHK,
    S_SHUP,
    S_WRNEW,
    S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          padj;

  assign padj = sts.prev_adj && (idx_r != '0);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    cmd       = '0;
    cmd.wr_sel   = rma_pkg::WD_ZERO;
    cmd.res_code = rma_pkg::ST_OK;
    rd_addr   = idx_r + IW'(1);
    wr_addr   = idx_r;
    in_tready = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        rd_addr   = '0;
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          cmd.rd_en    = 1'b1;
          idx_nxt      = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en = (idx_r != LAST);
        if (!sts.is_free) begin
          if (sts.rd_zero) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = rma_pkg::ST_NOFIT;
            state_nxt    = S_DONE;
          end else if (sts.fits) begin
            cmd.res_set       = 1'b1;
            cmd.res_take_base = 1'b1;
            if (sts.exact) begin
              state_nxt = (idx_r == LAST) ? S_CLR : S_SHDN;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = rma_pkg::WD_SHRINK;
              state_nxt  = S_DONE;
            end
          end else if (idx_r == LAST) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = rma_pkg::ST_NOFIT;
            state_nxt    = S_DONE;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end else if (sts.reject) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = rma_pkg::ST_BADFREE;
          state_nxt    = S_DONE;
        end else if (sts.stop) begin
          cmd.res_set = 1'b1;
          if (sts.overlap) begin
            cmd.res_code = rma_pkg::ST_BADFREE;
            state_nxt    = S_DONE;
          end else if (sts.rd_zero) begin
            cmd.wr_en = 1'b1;
            if (padj) begin
              wr_addr    = idx_r - IW'(1);
              cmd.wr_sel = rma_pkg::WD_PREV_LEN;
            end else begin
              cmd.wr_sel = rma_pkg::WD_NEW;
            end
            state_nxt = S_DONE;
          end else if (sts.end_eq) begin
            cmd.wr_en = 1'b1;
            if (padj) begin
              // fold the next extent into the previous one, then close the gap
              wr_addr    = idx_r - IW'(1);
              cmd.wr_sel = rma_pkg::WD_PREV_BOTH;
              state_nxt  = (idx_r == LAST) ? S_CLR : S_SHDN;
            end else begin
              cmd.wr_sel = rma_pkg::WD_NEXT_MERGE;
              state_nxt  = S_DONE;
            end
          end else if (padj) begin
            cmd.wr_en  = 1'b1;
            wr_addr    = idx_r - IW'(1);
            cmd.wr_sel = rma_pkg::WD_PREV_LEN;
            state_nxt  = S_DONE;
          end else begin
            // insert: fetch the last entry to see whether it falls off
            cmd.res_set = 1'b0;
            cmd.rd_en   = 1'b1;
            rd_addr     = LAST;
            k_nxt       = idx_r;
            state_nxt   = S_UPCHK;
          end
        end else begin
          cmd.save_prev = 1'b1;
          if (idx_r == LAST) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = rma_pkg::ST_BADFREE;
            state_nxt    = S_DONE;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      S_SHDN: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = rma_pkg::WD_COPY;
        if (idx_r == LAST - IW'(1)) begin
          state_nxt = S_CLR;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = idx_r + IW'(2);
          idx_nxt   = idx_r + IW'(1);
        end
      end
      S_CLR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = rma_pkg::WD_ZERO;
        wr_addr    = LAST;
        state_nxt  = S_DONE;
      end
      S_UPCHK: begin
        cmd.res_set  = 1'b1;
        cmd.res_code = sts.rd_zero ? rma_pkg::ST_OK : rma_pkg::ST_DROPPED;
        if (k_r == LAST) begin
          state_nxt = S_WRNEW;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = LAST - IW'(1);
          idx_nxt   = LAST;
          state_nxt = S_SHUP;
        end
      end
      S_SHUP: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = rma_pkg::WD_COPY;
        if (idx_r - IW'(1) == k_r) begin
          state_nxt = S_WRNEW;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = idx_r - IW'(2);
          idx_nxt   = idx_r - IW'(1);
        end
      end
      S_WRNEW: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = rma_pkg::WD_NEW;
        wr_addr    = k_r;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

### src/resource_map_allocator.sv
// ----------------------------------------------------------------------------
// resource_map_allocator: first-fit free-space map of extents
// Allocates and frees extents from a base-sorted table of free extents.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream in_*: in_tuser carries the command (0 allocate, 1 free),
//   in_tdata carries base_in and length_in. Each transfer produces exactly one
//   result transfer on out_*: out_tdata is the allocated base (zero on a
//   failure and for every free), out_tuser the status code.
//   One request at a time. The scan reads one table entry per cycle, paced
//   by the single read port of the extent memory; removing or inserting an
//   entry then shifts the entries behind it one per cycle. An insert scans
//   to the slot, fetches the last entry, shifts everything above the slot
//   and writes the new entry. The next input transfer can be taken in the
//   cycle after the result is loaded.
//   Reset (rst_n low, synchronous) empties the map at once by clearing the
//   per-entry valid bits; no clearing pass is needed.
//   Stall: a finished result waits in the output register while out_tready is
//   low; a new request is still taken during that wait, and its result holds
//   in the datapath until the output register frees up.
// ----------------------------------------------------------------------------
module resource_map_allocator #(
  parameter int MAP_ENTRIES = rma_pkg::MAP_ENTRIES_DEF,
  parameter int ADDR_BITS   = rma_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] base_in, [31:16] length_in
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] base_out
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int IW = $clog2(MAP_ENTRIES);

  rma_pkg::cmd_t cmd;
  rma_pkg::sts_t sts;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;

  // Sequencer: scan, merge and shift control, output handshake
  rma_ctrl #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .sts        (sts),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // Datapath: extent memory, compares, adders, result and output registers
  rma_datapath #(
    .MAP_ENTRIES (MAP_ENTRIES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .sts       (sts)
  );

endmodule
